[hw/rtl/rbfbf_pkg.sv]
package rbfbf_pkg;

	typedef logic [7:0][7:0] frame_t;

	typedef struct packed {
		frame_t     frame;
		logic       to_bus;
		logic [3:0] radio_n;
	} job_t;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_RADIO = 2'd1;
	localparam logic [1:0] ACT_BUS   = 2'd2;

	localparam logic       DIR_BUS   = 1'b0;
	localparam logic       DIR_RADIO = 1'b1;

	localparam logic       REG_TIMEOUT = 1'b0;
	localparam logic       REG_REPEAT  = 1'b1;

	localparam logic [7:0] MARK_FROM_RADIO = 8'h55;
	localparam logic [7:0] MARK_TO_RADIO   = 8'haa;
	localparam logic [7:0] AREA_ANY        = 8'hff;
	localparam logic [7:0] BED_ADD_CALL    = 8'd250;
	localparam logic [7:0] CODE_BED_ADD    = 8'h06;
	localparam logic [7:0] CODE_CALL_PASS  = 8'h5a;
	localparam logic [7:0] CODE_INDICATION = 8'h2f;
	localparam logic [7:0] INDICATION_MASK = 8'h1f;
	localparam logic [3:0] MAX_REPEATS     = 4'd8;

	localparam logic [15:0] TIMEOUT_RESET = 16'd12000;
	localparam logic [3:0]  REPEAT_RESET  = 4'd3;
	localparam logic [15:0] IDLE_RESET    = 16'd6001;

endpackage

[hw/rtl/rbfbf_frame_if.sv]
interface rbfbf_frame_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] byte0;
	logic [7:0] byte1;
	logic [7:0] byte2;
	logic [7:0] byte3;
	logic [7:0] byte4;
	logic [7:0] byte5;
	logic [7:0] byte6;
	logic [7:0] byte7;

	modport source (
		output valid, action, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
		input  ready
	);
	modport sink (
		input  valid, action, byte0, byte1, byte2, byte3, byte4, byte5, byte6, byte7,
		output ready
	);
endinterface

[hw/rtl/rbfbf_result_if.sv]
interface rbfbf_result_if;
	logic       valid;
	logic       ready;
	logic       destination;
	logic [7:0] out_byte0;
	logic [7:0] out_byte1;
	logic [7:0] out_byte2;
	logic [7:0] out_byte3;
	logic [7:0] out_byte4;
	logic [7:0] out_byte5;
	logic [7:0] out_byte6;
	logic [7:0] out_byte7;
	logic       last;

	modport source (
		output valid, destination, out_byte0, out_byte1, out_byte2, out_byte3,
		       out_byte4, out_byte5, out_byte6, out_byte7, last,
		input  ready
	);
	modport sink (
		input  valid, destination, out_byte0, out_byte1, out_byte2, out_byte3,
		       out_byte4, out_byte5, out_byte6, out_byte7, last,
		output ready
	);
endinterface

[hw/rtl/rbfbf_queue.sv]
module rbfbf_queue
	import rbfbf_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign head_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/rbfbf_front.sv]
module rbfbf_front
	import rbfbf_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	rbfbf_frame_if.sink   frame,
	input  logic          wr_en,
	input  logic          wr_index,
	input  logic [15:0]   wr_data,
	input  logic          q_full,
	output logic          q_push,
	output job_t          q_job
);

	logic [15:0] timeout_q;
	logic [3:0]  repeat_q;
	logic [7:0]  area_q;
	frame_t      prev_q;
	logic [15:0] idle_q;

	frame_t      in_frame;
	frame_t      bus_frame;
	logic        accept;
	logic [3:0]  rep_n;
	logic        radio_pass;
	logic        bed_add;
	logic        bus_pass;
	logic [15:0] idle_inc;

	assign frame.ready = !q_full;
	assign accept      = frame.valid && frame.ready;

	assign in_frame = {frame.byte7, frame.byte6, frame.byte5, frame.byte4,
	                   frame.byte3, frame.byte2, frame.byte1, frame.byte0};

	assign rep_n = (repeat_q > MAX_REPEATS) ? MAX_REPEATS : repeat_q;

	assign radio_pass = (frame.byte7 == MARK_FROM_RADIO)
	                 && ((area_q == AREA_ANY) || (area_q == frame.byte0))
	                 && (prev_q != in_frame);
	assign bed_add    = (frame.byte1 == BED_ADD_CALL) && (frame.byte3 == CODE_BED_ADD);
	assign bus_pass   = (frame.byte3 == CODE_CALL_PASS) || (frame.byte3 == CODE_INDICATION);

	always_comb begin
		bus_frame = in_frame;
		if (frame.byte3 == CODE_INDICATION) begin
			bus_frame[3] = frame.byte4 & INDICATION_MASK;
			bus_frame[4] = '0;
		end
	end

	assign idle_inc = (idle_q == 16'hffff) ? idle_q : idle_q + 16'd1;

	always_comb begin
		q_push = 1'b0;
		q_job  = '{frame: in_frame, to_bus: 1'b1, radio_n: bed_add ? rep_n : 4'd0};
		unique case (frame.action)
			ACT_RADIO: begin
				q_push = accept && radio_pass;
			end
			ACT_BUS: begin
				q_push = accept && bus_pass && (rep_n != 4'd0);
				q_job  = '{frame: bus_frame, to_bus: 1'b0, radio_n: rep_n};
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
			repeat_q  <= REPEAT_RESET;
			area_q    <= AREA_ANY;
			prev_q    <= '0;
			idle_q    <= IDLE_RESET;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_TIMEOUT: timeout_q <= wr_data;
					REG_REPEAT:  repeat_q  <= wr_data[3:0];
					default:     ;
				endcase
			end
			if (accept) begin
				unique case (frame.action)
					ACT_TICK: begin
						if (idle_inc > timeout_q) begin
							prev_q <= '0;
							idle_q <= '0;
						end else begin
							idle_q <= idle_inc;
						end
					end
					ACT_RADIO: begin
						if (radio_pass) begin
							prev_q <= in_frame;
							idle_q <= '0;
						end
					end
					ACT_BUS: begin
						if (bus_pass && (bus_frame[3] == CODE_BED_ADD)) begin
							area_q <= frame.byte0;
						end
					end
					default: ;
				endcase
			end
		end
	end

endmodule

[hw/rtl/rbfbf_back.sv]
module rbfbf_back
	import rbfbf_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  job_t            q_job,
	output logic            q_pop,
	rbfbf_result_if.source  result
);

	logic       cur_valid_q;
	logic       bus_q;
	logic [3:0] left_q;
	frame_t     frame_q;

	logic       res_valid_q;
	logic       res_dest_q;
	frame_t     res_frame_q;
	logic       res_last_q;

	logic       emit;
	logic       emit_last;
	frame_t     emit_frame;

	assign emit      = cur_valid_q && (!res_valid_q || result.ready);
	assign emit_last = bus_q ? (left_q == 4'd0) : (left_q == 4'd1);
	assign q_pop     = !q_empty && (!cur_valid_q || (emit && emit_last));

	always_comb begin
		emit_frame = frame_q;
		if (!bus_q) begin
			emit_frame[7] = MARK_TO_RADIO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			bus_q       <= 1'b0;
			left_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
				bus_q       <= q_job.to_bus;
				left_q      <= q_job.radio_n;
			end else if (emit && emit_last) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				if (bus_q) begin
					bus_q <= 1'b0;
				end else begin
					left_q <= left_q - 4'd1;
				end
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			frame_q <= q_job.frame;
		end
		if (emit) begin
			res_dest_q  <= bus_q ? DIR_BUS : DIR_RADIO;
			res_frame_q <= emit_frame;
			res_last_q  <= emit_last;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.destination = res_dest_q;
	assign result.out_byte0   = res_frame_q[0];
	assign result.out_byte1   = res_frame_q[1];
	assign result.out_byte2   = res_frame_q[2];
	assign result.out_byte3   = res_frame_q[3];
	assign result.out_byte4   = res_frame_q[4];
	assign result.out_byte5   = res_frame_q[5];
	assign result.out_byte6   = res_frame_q[6];
	assign result.out_byte7   = res_frame_q[7];
	assign result.last        = res_last_q;

endmodule

[hw/rtl/radio_bus_frame_bridge_filter_top.sv]
// Channel   Role    Beat contents
// frame     sink    action, byte0 .. byte7
// result    source  destination, out_byte0 .. out_byte7, last
// wr_*      write   wr_index selects timeout_limit (0) or repeat_count (1)
//
// The front takes one frame beat per cycle while the job queue has room and
// updates the filter state at once. The back sends one result beat per cycle
// while the receiver is ready; an input yields 1 to 9 result beats, and an
// input with no results is not queued and costs the back nothing.
// Reset is asynchronous and restores the register and filter defaults.
// A stall on the result side fills the queue before the frame side stalls.
module radio_bus_frame_bridge_filter_top
	import rbfbf_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	rbfbf_frame_if.sink    frame,
	rbfbf_result_if.source result,
	input  logic           wr_en,
	input  logic           wr_index,
	input  logic [15:0]    wr_data
);

	logic q_full;
	logic q_push;
	job_t q_in_job;
	logic q_empty;
	logic q_pop;
	job_t q_head_job;

	rbfbf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame    (frame),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (q_in_job)
	);

	rbfbf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_in_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head_job (q_head_job)
	);

	rbfbf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_job   (q_head_job),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule

[hw/rtl/rbfbf_checker.sv]
module rbfbf_checker
	import rbfbf_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_dest,
	input logic [7:0] res_byte1,
	input logic [7:0] res_byte3,
	input logic [7:0] res_byte7,
	input logic       res_last
);

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("Result beat dropped while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_byte7) && $stable(res_last))
		else $error("Result beat changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_dest == DIR_RADIO) ? (res_byte7 == MARK_TO_RADIO)
		                                      : (res_byte7 == MARK_FROM_RADIO))
		else $error("Direction marker does not match destination.");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_dest == DIR_BUS) && !res_last
		|-> (res_byte1 == BED_ADD_CALL) && (res_byte3 == CODE_BED_ADD))
		else $error("Bus beat followed by radio beats without a bed-add call.");

endmodule

bind radio_bus_frame_bridge_filter_top rbfbf_checker u_rbfbf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_dest  (result.destination),
	.res_byte1 (result.out_byte1),
	.res_byte3 (result.out_byte3),
	.res_byte7 (result.out_byte7),
	.res_last  (result.last)
);

[verif/tb_radio_bus_frame_bridge_filter_top.sv]
`timescale 1ns / 1ps

module tb_radio_bus_frame_bridge_filter_top;
	import rbfbf_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 80;
	localparam int ITEMS_PER_PHASE = 16;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic   dest;
		frame_t data;
		logic   last;
	} send_t;

	class bridge_tracker;
		logic [15:0] timeout_limit;
		logic [3:0]  repeat_count;
		logic [7:0]  area;
		frame_t      prev_frame;
		logic [15:0] idle_ticks;
		send_t       pending_sends[$];
		int          errors;
		int          useful;

		function new();
			timeout_limit = TIMEOUT_RESET;
			repeat_count = REPEAT_RESET;
			area = AREA_ANY;
			prev_frame = '0;
			idle_ticks = IDLE_RESET;
			errors = 0;
			useful = 0;
		endfunction

		function void write_reg(logic index, logic [15:0] value);
			if (index == REG_TIMEOUT) begin
				timeout_limit = value;
			end else begin
				repeat_count = value[3:0];
			end
		endfunction

		function void push_send(logic dest, frame_t data);
			send_t s;
			s.dest = dest;
			s.data = data;
			s.last = 1'b0;
			pending_sends.push_back(s);
		endfunction

		function void push_radio(frame_t data);
			int sends;
			sends = (repeat_count > MAX_REPEATS) ? MAX_REPEATS : repeat_count;
			for (int i = 0; i < sends; i++)
				push_send(DIR_RADIO, data);
		endfunction

		function void note_frame(logic [1:0] action, frame_t f);
			int before_count;
			before_count = pending_sends.size();
			case (action)
			ACT_TICK: begin
				if (idle_ticks != 16'hffff)
					idle_ticks++;
				if (idle_ticks > timeout_limit) begin
					prev_frame = '0;
					idle_ticks = '0;
				end
			end
			ACT_RADIO: begin
				if (f[7] == MARK_FROM_RADIO && (area == AREA_ANY || area == f[0]) &&
						f != prev_frame) begin
					idle_ticks = '0;
					push_send(DIR_BUS, f);
					prev_frame = f;
					if (f[1] == BED_ADD_CALL && f[3] == CODE_BED_ADD) begin
						f[7] = MARK_TO_RADIO;
						push_radio(f);
					end
				end
			end
			ACT_BUS: begin
				if (f[3] == CODE_CALL_PASS || f[3] == CODE_INDICATION) begin
					if (f[3] == CODE_INDICATION) begin
						f[3] = f[4] & INDICATION_MASK;
						f[4] = '0;
					end
					if (f[3] == CODE_BED_ADD)
						area = f[0];
					f[7] = MARK_TO_RADIO;
					push_radio(f);
				end
			end
			default: ;
			endcase
			if (pending_sends.size() > before_count) begin
				pending_sends[pending_sends.size() - 1].last = 1'b1;
				useful++;
			end else if (action == ACT_TICK) begin
				useful++;
			end
		endfunction

		function void check_send(send_t got);
			send_t want;
			if (pending_sends.size() == 0) begin
				$error("unexpected result beat: destination %0d, frame %h, last %0d",
					got.dest, got.data, got.last);
				errors++;
				return;
			end
			want = pending_sends.pop_front();
			if (got.dest !== want.dest) begin
				$error("destination: expected %0d, got %0d", want.dest, got.dest);
				errors++;
			end
			for (int j = 0; j < 8; j++) begin
				if (got.data[j] !== want.data[j]) begin
					$error("out_byte%0d: expected %h, got %h", j, want.data[j], got.data[j]);
					errors++;
				end
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, got %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic        wr_index;
	logic [15:0] wr_data;

	rbfbf_frame_if  frame_ch();
	rbfbf_result_if result_ch();

	bridge_tracker tracker;
	int            idle_pct;
	int            stall_pct;
	bit            hold_req;
	int            cycle_count = 0;
	frame_t        last_radio;
	frame_t        dup_frame;
	frame_t        bed_frame;

	radio_bus_frame_bridge_filter_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.frame   (frame_ch),
		.result  (result_ch),
		.wr_en   (wr_en),
		.wr_index(wr_index),
		.wr_data (wr_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready)
			tracker.note_frame(frame_ch.action, {frame_ch.byte7, frame_ch.byte6, frame_ch.byte5,
				frame_ch.byte4, frame_ch.byte3, frame_ch.byte2, frame_ch.byte1, frame_ch.byte0});
		if (arst_n && result_ch.valid && result_ch.ready)
			tracker.check_send({result_ch.destination, result_ch.out_byte7, result_ch.out_byte6,
				result_ch.out_byte5, result_ch.out_byte4, result_ch.out_byte3, result_ch.out_byte2,
				result_ch.out_byte1, result_ch.out_byte0, result_ch.last});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("radio_bus_frame_bridge_filter_top: mismatch");
			$finish;
		end
	end

	// The receiver holds off for a long stretch on request so that the job queue fills.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic frame_t bytes8(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3, logic [7:0] b4, logic [7:0] b5, logic [7:0] b6, logic [7:0] b7);
		return {b7, b6, b5, b4, b3, b2, b1, b0};
	endfunction

	task automatic send_frame(logic [1:0] action, frame_t f);
		while ($urandom_range(99) < idle_pct) begin
			frame_ch.valid <= 1'b0;
			@(posedge clk);
		end
		frame_ch.valid <= 1'b1;
		frame_ch.action <= action;
		frame_ch.byte0 <= f[0];
		frame_ch.byte1 <= f[1];
		frame_ch.byte2 <= f[2];
		frame_ch.byte3 <= f[3];
		frame_ch.byte4 <= f[4];
		frame_ch.byte5 <= f[5];
		frame_ch.byte6 <= f[6];
		frame_ch.byte7 <= f[7];
		do @(posedge clk); while (!frame_ch.ready);
	endtask

	task automatic drain();
		frame_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_sends.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(logic [15:0] timeout_value, logic [15:0] repeat_value);
		wr_en <= 1'b1;
		wr_index <= REG_TIMEOUT;
		wr_data <= timeout_value;
		@(posedge clk);
		wr_index <= REG_REPEAT;
		wr_data <= repeat_value;
		@(posedge clk);
		wr_en <= 1'b0;
		tracker.write_reg(REG_TIMEOUT, timeout_value);
		tracker.write_reg(REG_REPEAT, repeat_value);
	endtask

	// Mostly frames that pass the filters, with noise and broken frames mixed in.
	task automatic send_random();
		int     r;
		logic [1:0] action;
		frame_t f;
		r = $urandom_range(99);
		f = {$urandom(), $urandom()};
		if (r < 8) begin
			action = ACT_UNUSED;
		end else if (r < 24) begin
			action = ACT_TICK;
		end else if (r < 62) begin
			action = ACT_RADIO;
			if ($urandom_range(9) != 0)
				f[7] = MARK_FROM_RADIO;
			if (tracker.area != AREA_ANY && $urandom_range(4) != 0)
				f[0] = tracker.area;
			if ($urandom_range(9) < 3) begin
				f[1] = BED_ADD_CALL;
				f[3] = CODE_BED_ADD;
			end
			if ($urandom_range(9) == 0)
				f = last_radio;
			last_radio = f;
		end else begin
			action = ACT_BUS;
			case ($urandom_range(9))
			0: ;
			1, 2, 3, 4: f[3] = CODE_CALL_PASS;
			default: f[3] = CODE_INDICATION;
			endcase
			if ($urandom_range(2) == 0) begin
				f[4] = (f[4] & ~INDICATION_MASK) | CODE_BED_ADD;
				if ($urandom_range(2) == 0)
					f[0] = AREA_ANY;
			end
		end
		send_frame(action, f);
	endtask

	initial begin
		tracker = new();
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_TIMEOUT;
		wr_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.action = ACT_TICK;
		frame_ch.byte0 = '0;
		frame_ch.byte1 = '0;
		frame_ch.byte2 = '0;
		frame_ch.byte3 = '0;
		frame_ch.byte4 = '0;
		frame_ch.byte5 = '0;
		frame_ch.byte6 = '0;
		frame_ch.byte7 = '0;
		idle_pct = 0;
		stall_pct = 0;
		hold_req = 1'b0;
		last_radio = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		dup_frame = bytes8(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, MARK_FROM_RADIO);
		send_frame(ACT_RADIO, dup_frame);
		send_frame(ACT_RADIO, dup_frame);
		send_frame(ACT_RADIO, bytes8(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h54));
		send_frame(ACT_RADIO, bytes8(8'h12, BED_ADD_CALL, 8'h00, CODE_BED_ADD, 8'hff, 8'hff,
			8'hff, MARK_FROM_RADIO));
		send_frame(ACT_UNUSED, '1);
		send_frame(ACT_BUS, bytes8(8'h33, 8'h80, 8'h7f, CODE_CALL_PASS, 8'he6, 8'h01, 8'hfe,
			8'h00));
		send_frame(ACT_BUS, bytes8(8'h21, 8'h01, 8'h02, CODE_INDICATION, 8'he6, 8'h03, 8'h04,
			8'hff));
		send_frame(ACT_RADIO, bytes8(8'h22, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
			MARK_FROM_RADIO));
		send_frame(ACT_RADIO, bytes8(8'h21, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 8'h0f, 8'hf0,
			MARK_FROM_RADIO));
		send_frame(ACT_BUS, bytes8(8'hff, 8'h00, 8'h00, CODE_INDICATION, 8'h1f, 8'h00, 8'h00,
			8'h55));
		send_frame(ACT_BUS, bytes8(8'h21, 8'h00, 8'h00, 8'h07, 8'h06, 8'h00, 8'h00, 8'h00));
		send_frame(ACT_BUS, bytes8(AREA_ANY, 8'h00, 8'h00, CODE_INDICATION, CODE_BED_ADD, 8'h00,
			8'h00, 8'h00));
		dup_frame = bytes8(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, MARK_FROM_RADIO);
		send_frame(ACT_RADIO, dup_frame);

		// The stored frame is cleared on the tick that passes the limit, not before.
		drain();
		set_registers(16'd2, 16'd3);
		send_frame(ACT_TICK, '0);
		send_frame(ACT_TICK, '1);
		send_frame(ACT_RADIO, dup_frame);
		send_frame(ACT_TICK, '0);
		send_frame(ACT_RADIO, dup_frame);

		drain();
		set_registers(16'd0, 16'd0);
		bed_frame = bytes8(8'h40, BED_ADD_CALL, 8'h00, CODE_BED_ADD, 8'h00, 8'h00, 8'h00,
			MARK_FROM_RADIO);
		send_frame(ACT_RADIO, bed_frame);
		send_frame(ACT_BUS, bytes8(8'h40, 8'h00, 8'h00, CODE_CALL_PASS, 8'h00, 8'h00, 8'h00,
			8'h00));
		send_frame(ACT_TICK, '0);

		drain();
		set_registers(16'd0, 16'd15);
		send_frame(ACT_RADIO, bed_frame);

		// A tick under the largest limits leaves the stored frame in place.
		drain();
		set_registers(16'hffff, 16'd1);
		send_frame(ACT_TICK, '0);
		send_frame(ACT_RADIO, bed_frame);
		drain();
		set_registers(16'hfffe, 16'd1);
		send_frame(ACT_TICK, '0);
		send_frame(ACT_RADIO, bed_frame);

		for (int p = 0; p < 4; p++) begin
			int n;
			drain();
			case (p)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
				set_registers(16'd6, 16'd1);
			end
			1: begin
				idle_pct = 67;
				stall_pct = 0;
				set_registers(16'd65534, 16'd8);
			end
			2: begin
				idle_pct = 0;
				stall_pct = 67;
				set_registers(16'd3, 16'd5);
			end
			default: begin
				idle_pct = 27;
				stall_pct = 27;
				set_registers(16'd0, 16'd2);
			end
			endcase
			tracker.useful = 0;
			n = 0;
			while (tracker.useful < ITEMS_PER_PHASE) begin
				if (p == 0 && n == 6)
					hold_req = 1'b1;
				send_random();
				n++;
			end
		end

		drain();
		if (tracker.errors == 0) begin
			$display("radio_bus_frame_bridge_filter_top: match");
		end else begin
			$display("radio_bus_frame_bridge_filter_top: mismatch");
		end
		$finish;
	end

endmodule
